FILE: sv/mse_pkg.sv
// Types and constants shared by the MIPS subset executor.
package mse_pkg;

   // item kinds on the request channel
   localparam logic ITEM_EXEC = 1'b0;
   localparam logic ITEM_LOAD = 1'b1;

   // primary opcodes
   localparam logic [5:0] OP_RTYPE = 6'd0;
   localparam logic [5:0] OP_J     = 6'd2;
   localparam logic [5:0] OP_JAL   = 6'd3;
   localparam logic [5:0] OP_BEQ   = 6'd4;
   localparam logic [5:0] OP_BNE   = 6'd5;
   localparam logic [5:0] OP_ADDI  = 6'd8;
   localparam logic [5:0] OP_ADDIU = 6'd9;
   localparam logic [5:0] OP_ANDI  = 6'd12;
   localparam logic [5:0] OP_ORI   = 6'd13;
   localparam logic [5:0] OP_LUI   = 6'd15;
   localparam logic [5:0] OP_LW    = 6'd35;
   localparam logic [5:0] OP_SW    = 6'd43;

   // R-type function codes
   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_SLT  = 6'd42;

   // fault codes
   localparam logic [1:0] FAULT_OK    = 2'd0;
   localparam logic [1:0] FAULT_UNSUP = 2'd1;
   localparam logic [1:0] FAULT_ADDR  = 2'd2;

   localparam logic [31:0] BASE_ADDR = 32'h0040_0000;
   localparam logic [4:0]  REG_ZERO  = 5'd0;
   localparam logic [4:0]  REG_SP    = 5'd29;
   localparam logic [4:0]  REG_RA    = 5'd31;

   typedef struct packed {
      logic        opcode;
      logic [31:0] instr_word;
      logic [10:0] load_index;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        mem_written;
      logic [31:0] mem_address;
      logic [31:0] mem_value;
      logic [1:0]  fault;
   } rsp_type;

endpackage

FILE: sv/mips_subset_instruction_executor.sv
// Top level of the MIPS subset executor: register file, word memory, execute stage.
//
// Usage:
//  - req channel: each item either executes instr_word (opcode 0) or preloads
//    load_data into word load_index of the word memory (opcode 1).
//  - rsp channel: one result per item, in order: new pc, the register or
//    memory word written, and a fault code.
//  - Throughput: one item per cycle while the receiver does not stall; the
//    execute stage and the result register form a
//    two-deep pipeline, and the register file and memory each commit one
//    write per cycle.
//  - A load's word comes straight from the registered memory read port; the
//    register file write for it lands in the cycle after commit and is bypassed.
//  - Reset: pc = 0x00400000, registers zero except r29 = stack top (end of the
//    memory window), halt cleared. Memory contents are undefined until
//    written; no clearing pass, items are taken from the first cycle.
//  - Receiver stall: the result register holds, one more item sits in the
//    execute stage, then req_ready drops until rsp_ready returns.
//  - A fault on an execute item sets a sticky halt; later execute items report only the pc.
module mips_subset_instruction_executor #(
   parameter int INSTR_WORDS = 1024,
   parameter int DATA_WORDS  = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mse_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mse_pkg::rsp_type rsp_data
);
   import mse_pkg::*;

   localparam int          MEM_WORDS   = INSTR_WORDS + DATA_WORDS;
   localparam int          MIDX_W      = $clog2(MEM_WORDS);
   localparam logic [31:0] MEM_WORDS_W = 32'(MEM_WORDS);
   localparam logic [31:0] END_ADDR    = BASE_ADDR + 32'(4 * MEM_WORDS);

   // execute stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_item_ff;
   logic    advance;

   // state
   logic [31:0] pc_ff;
   logic        halted_ff;
   logic [31:0] reg_mem [32];
   logic [31:0] reg_vld_ff;
   logic [31:0] rdata_a_ff, rdata_b_ff;
   logic [31:0] word_mem [MEM_WORDS];
   logic [31:0] mem_rdata_ff;

   // write-back and bypass
   logic        wb_en_ff, wb_load_ff;
   logic [4:0]  wb_idx_ff;
   logic [31:0] wb_val_ff, wb_data;
   logic        last_en_ff;
   logic [4:0]  last_idx_ff;
   logic [31:0] last_val_ff;

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   logic    rsp_load_ff;

   // read addresses
   logic [31:0] rd_word;
   logic [4:0]  rd_rs, rd_rt;

   // execute signals
   logic [31:0] ins;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sh;
   logic [31:0] imm_s, imm_z, a, b, pc4, ea, ea_off, li_ext;
   logic        ea_ok, li_ok;
   logic [MIDX_W-1:0] ea_idx, li_idx;

   logic [31:0] x_npc, x_wval, x_maddr, x_mval;
   logic [4:0]  x_wreg;
   logic        x_rw, x_load, x_mw, x_set_halt, x_pc_we;
   logic [1:0]  x_fault;
   logic [MIDX_W-1:0] x_midx;

   // handshake
   assign advance     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
   end

   // register file read, re-read every cycle so a held item sees all writes
   assign rd_word = req_ready ? req_data.instr_word : s1_item_ff.instr_word;
   assign rd_rs   = rd_word[25:21];
   assign rd_rt   = rd_word[20:16];

   always_ff @(posedge clock) begin
      rdata_a_ff <= reg_vld_ff[rd_rs] ? reg_mem[rd_rs] :
                    ((rd_rs == REG_SP) ? END_ADDR : '0);
      rdata_b_ff <= reg_vld_ff[rd_rt] ? reg_mem[rd_rt] :
                    ((rd_rt == REG_SP) ? END_ADDR : '0);
      if (wb_en_ff) begin
         reg_mem[wb_idx_ff] <= wb_data;
      end
   end

   assign wb_data = wb_load_ff ? mem_rdata_ff : wb_val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_vld_ff <= '0;
         wb_en_ff   <= 1'b0;
         last_en_ff <= 1'b0;
      end else begin
         wb_en_ff <= advance && x_rw;
         if (wb_en_ff) begin
            reg_vld_ff[wb_idx_ff] <= 1'b1;
            last_en_ff            <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wb_idx_ff  <= x_wreg;
         wb_load_ff <= x_load;
         wb_val_ff  <= x_wval;
      end
      if (wb_en_ff) begin
         last_idx_ff <= wb_idx_ff;
         last_val_ff <= wb_data;
      end
   end

   // bypass: pending write-back first, then the write done at the last edge
   function automatic logic [31:0] bypass(input logic [4:0] idx, input logic [31:0] rdata,
                                          input logic wen, input logic [4:0] widx,
                                          input logic [31:0] wval, input logic len,
                                          input logic [4:0] lidx, input logic [31:0] lval);
      logic [31:0] val;
      if (wen && widx == idx) begin
         val = wval;
      end else if (len && lidx == idx) begin
         val = lval;
      end else begin
         val = rdata;
      end
      return val;
   endfunction

   // execute
   assign ins    = s1_item_ff.instr_word;
   assign op     = ins[31:26];
   assign rs     = ins[25:21];
   assign rt     = ins[20:16];
   assign rd     = ins[15:11];
   assign sh     = ins[10:6];
   assign fn     = ins[5:0];
   assign imm_s  = {{16{ins[15]}}, ins[15:0]};
   assign imm_z  = {16'h0000, ins[15:0]};
   assign a      = bypass(rs, rdata_a_ff, wb_en_ff, wb_idx_ff, wb_data,
                          last_en_ff, last_idx_ff, last_val_ff);
   assign b      = bypass(rt, rdata_b_ff, wb_en_ff, wb_idx_ff, wb_data,
                          last_en_ff, last_idx_ff, last_val_ff);
   assign pc4    = pc_ff + 32'd4;
   assign ea     = a + imm_s;
   assign ea_off = ea - BASE_ADDR;
   assign ea_ok  = (ea[1:0] == 2'b00) && (ea >= BASE_ADDR) && (ea < END_ADDR);
   assign ea_idx = ea_off[MIDX_W+1:2];
   assign li_ext = {21'h0, s1_item_ff.load_index};
   assign li_ok  = li_ext < MEM_WORDS_W;
   assign li_idx = li_ext[MIDX_W-1:0];

   always_comb begin
      x_npc      = pc_ff;
      x_rw       = 1'b0;
      x_wreg     = REG_ZERO;
      x_wval     = '0;
      x_load     = 1'b0;
      x_mw       = 1'b0;
      x_maddr    = '0;
      x_mval     = '0;
      x_midx     = '0;
      x_fault    = FAULT_OK;
      x_set_halt = 1'b0;
      x_pc_we    = 1'b0;
      if (s1_item_ff.opcode == ITEM_LOAD) begin
         if (li_ok) begin
            x_mw    = 1'b1;
            x_midx  = li_idx;
            x_maddr = BASE_ADDR + {li_ext[29:0], 2'b00};
            x_mval  = s1_item_ff.load_data;
         end else begin
            x_fault = FAULT_ADDR;
         end
      end else if (!halted_ff) begin
         x_npc = pc4;
         unique case (op)
            OP_RTYPE: begin
               x_rw   = 1'b1;
               x_wreg = rd;
               unique case (fn)
                  FN_ADD, FN_ADDU: x_wval = a + b;
                  FN_SUB, FN_SUBU: x_wval = a - b;
                  FN_AND:          x_wval = a & b;
                  FN_OR:           x_wval = a | b;
                  FN_SLT:          x_wval = {31'h0, $signed(a) < $signed(b)};
                  FN_SLL:          x_wval = b << sh;
                  FN_SRL:          x_wval = b >> sh;
                  FN_JR: begin
                     x_rw  = 1'b0;
                     x_npc = a;
                  end
                  default: begin
                     x_rw    = 1'b0;
                     x_fault = FAULT_UNSUP;
                  end
               endcase
            end
            OP_ADDI, OP_ADDIU: begin
               x_rw = 1'b1; x_wreg = rt; x_wval = a + imm_s;
            end
            OP_ANDI: begin
               x_rw = 1'b1; x_wreg = rt; x_wval = a & imm_z;
            end
            OP_ORI: begin
               x_rw = 1'b1; x_wreg = rt; x_wval = a | imm_z;
            end
            OP_LUI: begin
               x_rw = 1'b1; x_wreg = rt; x_wval = {ins[15:0], 16'h0000};
            end
            OP_BEQ: begin
               if (a == b) x_npc = pc4 + {imm_s[29:0], 2'b00};
            end
            OP_BNE: begin
               if (a != b) x_npc = pc4 + {imm_s[29:0], 2'b00};
            end
            OP_LW: begin
               if (!ea_ok) begin
                  x_fault = FAULT_ADDR;
               end else begin
                  x_rw = 1'b1; x_wreg = rt; x_load = 1'b1; x_midx = ea_idx;
               end
            end
            OP_SW: begin
               if (!ea_ok) begin
                  x_fault = FAULT_ADDR;
               end else begin
                  x_mw = 1'b1; x_midx = ea_idx; x_maddr = ea; x_mval = b;
               end
            end
            OP_J: begin
               x_npc = {pc4[31:28], ins[25:0], 2'b00};
            end
            OP_JAL: begin
               x_npc  = {pc4[31:28], ins[25:0], 2'b00};
               x_rw   = 1'b1;
               x_wreg = REG_RA;
               x_wval = pc4 + 32'd4;
            end
            default: x_fault = FAULT_UNSUP;
         endcase
         if (x_fault != FAULT_OK) begin
            x_set_halt = 1'b1;
            x_rw       = 1'b0;
            x_load     = 1'b0;
            x_mw       = 1'b0;
            x_npc      = pc_ff;
         end else begin
            x_pc_we = 1'b1;
            if (x_wreg == REG_ZERO) begin
               x_rw   = 1'b0;
               x_load = 1'b0;
            end
         end
      end
      if (!x_rw) begin
         x_wreg = REG_ZERO;
         x_wval = '0;
      end
   end

   // word memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (advance && x_mw) begin
         word_mem[x_midx] <= x_mval;
      end
      if (advance && x_load) begin
         mem_rdata_ff <= word_mem[x_midx];
      end
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff     <= BASE_ADDR;
         halted_ff <= 1'b0;
      end else if (advance) begin
         if (x_pc_we) pc_ff <= x_npc;
         if (x_set_halt) halted_ff <= 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.next_pc     <= x_npc;
         rsp_ff.reg_written <= x_rw;
         rsp_ff.reg_index   <= x_wreg;
         rsp_ff.reg_value   <= x_wval;
         rsp_ff.mem_written <= x_mw;
         rsp_ff.mem_address <= x_maddr;
         rsp_ff.mem_value   <= x_mval;
         rsp_ff.fault       <= x_fault;
         rsp_load_ff        <= x_load;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data = rsp_ff;
      if (rsp_load_ff) begin
         rsp_data.reg_value = mem_rdata_ff;
      end
   end

   // checks
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt flag cleared without reset");

   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      wb_en_ff |-> (wb_idx_ff != REG_ZERO))
      else $error("write-back targets r0");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fault != FAULT_OK) |->
         (!rsp_ff.reg_written && !rsp_ff.mem_written))
      else $error("faulting item reports a write");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with room in the pipeline");

   a_halted_pc_hold: assert property (@(posedge clock) disable iff (reset)
      (halted_ff && advance) |=> $stable(pc_ff))
      else $error("pc moved while halted");

endmodule

FILE: test/testbench.sv
// Testbench for the MIPS subset executor: directed and random items against an in-bench model.
`timescale 1ns / 1ps

module testbench;
   import mse_pkg::*;

   localparam int MEM_WORDS  = 2048;
   localparam int TIMEOUT_NS = 10_000_000;

   typedef enum int {
      HALT_BAD_OPCODE,
      HALT_BAD_FUNCT,
      HALT_MISALIGNED,
      HALT_BELOW_WINDOW,
      HALT_PAST_WINDOW
   } halt_case_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // executor state as predicted
   logic [31:0] gpr [32];
   logic [31:0] pc_q;
   logic [31:0] word_mem [MEM_WORDS];
   bit          word_known [MEM_WORDS];
   int          known_words [$];
   bit          halted_q;

   rsp_type       retire_queue [$];
   rsp_type       oldest;
   int            idle_pct = 26;
   int            mismatch_count;
   int            items_sent;
   int            preloads_sent;
   int            results_checked;
   halt_case_type halt_case;

   mips_subset_instruction_executor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh);
      return {OP_RTYPE, rs, rt, rd, sh, fn};
   endfunction

   function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] target);
      return {op, target};
   endfunction

   function automatic req_type exec_item(logic [31:0] word);
      req_type item;
      item.opcode     = ITEM_EXEC;
      item.instr_word = word;
      item.load_index = 11'($urandom);
      item.load_data  = $urandom;
      return item;
   endfunction

   function automatic req_type load_item(int idx, logic [31:0] data);
      req_type item;
      item.opcode     = ITEM_LOAD;
      item.instr_word = $urandom;
      item.load_index = idx[10:0];
      item.load_data  = data;
      return item;
   endfunction

   function automatic void commit_word(int idx, logic [31:0] data);
      word_mem[idx] = data;
      if (!word_known[idx]) begin
         word_known[idx] = 1'b1;
         known_words.push_back(idx);
      end
   endfunction

   // one item through the executor model: updates state, returns the result
   function automatic rsp_type retire_item(req_type item);
      rsp_type     res;
      logic [31:0] ins, a, b, imm_s, imm_z, pc4, npc, wval, addr, off;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sh, wreg;
      logic        rw;
      logic [1:0]  flt;
      res  = '0;
      rw   = 1'b0;
      wreg = '0;
      wval = '0;
      flt  = FAULT_OK;
      npc  = pc_q;
      ins  = item.instr_word;
      if (item.opcode == ITEM_LOAD) begin
         if (item.load_index < MEM_WORDS) begin
            commit_word(int'(item.load_index), item.load_data);
            res.mem_written = 1'b1;
            res.mem_address = BASE_ADDR + {item.load_index, 2'b00};
            res.mem_value   = item.load_data;
         end else begin
            flt = FAULT_ADDR;
         end
      end else if (!halted_q) begin
         op    = ins[31:26];
         rs    = ins[25:21];
         rt    = ins[20:16];
         rd    = ins[15:11];
         sh    = ins[10:6];
         fn    = ins[5:0];
         a     = gpr[rs];
         b     = gpr[rt];
         imm_s = {{16{ins[15]}}, ins[15:0]};
         imm_z = {16'h0000, ins[15:0]};
         pc4   = pc_q + 32'd4;
         npc   = pc4;
         case (op)
            OP_RTYPE: begin
               rw   = 1'b1;
               wreg = rd;
               case (fn)
                  FN_ADD, FN_ADDU: wval = a + b;
                  FN_SUB, FN_SUBU: wval = a - b;
                  FN_AND:          wval = a & b;
                  FN_OR:           wval = a | b;
                  FN_SLT:          wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                  FN_SLL:          wval = b << sh;
                  FN_SRL:          wval = b >> sh;
                  FN_JR: begin
                     rw  = 1'b0;
                     npc = a;
                  end
                  default: begin
                     rw  = 1'b0;
                     flt = FAULT_UNSUP;
                  end
               endcase
            end
            OP_ADDI, OP_ADDIU: begin
               rw = 1'b1; wreg = rt; wval = a + imm_s;
            end
            OP_ANDI: begin
               rw = 1'b1; wreg = rt; wval = a & imm_z;
            end
            OP_ORI: begin
               rw = 1'b1; wreg = rt; wval = a | imm_z;
            end
            OP_LUI: begin
               rw = 1'b1; wreg = rt; wval = {ins[15:0], 16'h0000};
            end
            OP_BEQ, OP_BNE: begin
               if ((a == b) == (op == OP_BEQ)) npc = pc4 + (imm_s << 2);
            end
            OP_LW, OP_SW: begin
               addr = a + imm_s;
               off  = (addr - BASE_ADDR) >> 2;
               if (addr[1:0] != 2'b00 || addr < BASE_ADDR || off >= MEM_WORDS) begin
                  flt = FAULT_ADDR;
               end else if (op == OP_LW) begin
                  rw = 1'b1; wreg = rt; wval = word_mem[int'(off)];
               end else begin
                  commit_word(int'(off), b);
                  res.mem_written = 1'b1;
                  res.mem_address = addr;
                  res.mem_value   = b;
               end
            end
            OP_J, OP_JAL: begin
               npc = {pc4[31:28], ins[25:0], 2'b00};
               if (op == OP_JAL) begin
                  rw = 1'b1; wreg = REG_RA; wval = pc4 + 32'd4;
               end
            end
            default: flt = FAULT_UNSUP;
         endcase
         if (flt != FAULT_OK) begin
            halted_q = 1'b1;
            rw       = 1'b0;
            npc      = pc_q;
         end else begin
            if (wreg == REG_ZERO) rw = 1'b0;
            if (rw) gpr[wreg] = wval;
            pc_q = npc;
         end
      end
      res.next_pc     = npc;
      res.reg_written = rw;
      if (rw) begin
         res.reg_index = wreg;
         res.reg_value = wval;
      end
      res.fault = flt;
      return res;
   endfunction

   task automatic send_item(input req_type item);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      retire_queue.push_back(retire_item(item));
      items_sent++;
      if (item.opcode == ITEM_LOAD) preloads_sent++;
   endtask

   // well-formed item with random content; loads only read words already written
   task automatic build_random_item(output req_type item);
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd;
      logic [15:0] imm;
      logic [31:0] target, diff;
      int          pick, idx, base_reg, start, r;
      bit          is_load;
      pick = $urandom_range(99);
      rs   = 5'($urandom);
      rt   = 5'($urandom);
      rd   = 5'($urandom);
      imm  = 16'($urandom);
      if (pick < 12) begin
         item = load_item($urandom_range(MEM_WORDS - 1), $urandom);
      end else if (pick < 45) begin
         case ($urandom_range(8))
            0: fn = FN_ADD;
            1: fn = FN_ADDU;
            2: fn = FN_SUB;
            3: fn = FN_SUBU;
            4: fn = FN_AND;
            5: fn = FN_OR;
            6: fn = FN_SLT;
            7: fn = FN_SLL;
            default: fn = FN_SRL;
         endcase
         item = exec_item(enc_r(fn, rs, rt, rd, 5'($urandom)));
      end else if (pick < 65) begin
         case ($urandom_range(4))
            0: op = OP_ADDI;
            1: op = OP_ADDIU;
            2: op = OP_ANDI;
            3: op = OP_ORI;
            default: op = OP_LUI;
         endcase
         item = exec_item(enc_i(op, rs, rt, imm));
      end else if (pick < 75) begin
         op = $urandom_range(1) ? OP_BEQ : OP_BNE;
         if ($urandom_range(99) < 40) rt = rs;
         item = exec_item(enc_i(op, rs, rt, imm));
      end else if (pick < 80) begin
         op = $urandom_range(1) ? OP_J : OP_JAL;
         item = exec_item(enc_j(op, 26'($urandom)));
      end else if (pick < 83) begin
         item = exec_item(enc_r(FN_JR, rs, rt, rd, 5'($urandom)));
      end else begin
         is_load  = (known_words.size() != 0) && ($urandom_range(1) == 1);
         idx      = is_load ? known_words[$urandom_range(known_words.size() - 1)]
                            : $urandom_range(MEM_WORDS - 1);
         target   = BASE_ADDR + 32'(idx) * 4;
         base_reg = -1;
         start    = $urandom_range(31);
         for (int k = 0; k < 32; k++) begin
            r    = (start + k) % 32;
            diff = target - gpr[r];
            if (base_reg < 0 && $signed(diff) >= -32768 && $signed(diff) <= 32767)
               base_reg = r;
         end
         if (base_reg < 0) begin
            // no register near the window: point one at its base
            item = exec_item(enc_i(OP_LUI, rs, (rt == REG_ZERO) ? 5'd1 : rt,
                                   BASE_ADDR[31:16]));
         end else begin
            diff = target - gpr[base_reg];
            item = exec_item(enc_i(is_load ? OP_LW : OP_SW, 5'(base_reg), rt, diff[15:0]));
         end
      end
   endtask

   task automatic test_preload();
      send_item(load_item(0, 32'hFFFF_FFFF));
      send_item(load_item(MEM_WORDS - 1, 32'h0000_0000));
   endtask

   task automatic test_alu_ops();
      send_item(exec_item(enc_i(OP_LUI, 5'd0, 5'd1, 16'hFFFF)));
      send_item(exec_item(enc_i(OP_ORI, 5'd1, 5'd1, 16'hFFFF)));
      send_item(exec_item(enc_i(OP_ANDI, 5'd1, 5'd2, 16'h8000)));
      send_item(exec_item(enc_i(OP_ADDI, 5'd2, 5'd3, 16'h8000)));
      send_item(exec_item(enc_i(OP_ADDIU, REG_ZERO, 5'd4, 16'h7FFF)));
      send_item(exec_item(enc_r(FN_ADD, 5'd1, 5'd4, 5'd5, 5'd0)));
      send_item(exec_item(enc_r(FN_ADDU, 5'd4, 5'd4, 5'd5, 5'd0)));
      send_item(exec_item(enc_r(FN_SUB, REG_ZERO, 5'd4, 5'd6, 5'd0)));
      send_item(exec_item(enc_r(FN_SUBU, 5'd3, 5'd1, 5'd6, 5'd0)));
      send_item(exec_item(enc_r(FN_AND, 5'd1, 5'd4, 5'd7, 5'd0)));
      send_item(exec_item(enc_r(FN_OR, 5'd2, 5'd4, 5'd7, 5'd0)));
      send_item(exec_item(enc_r(FN_SLT, 5'd1, 5'd4, 5'd8, 5'd0)));
      send_item(exec_item(enc_r(FN_SLL, 5'd0, 5'd1, 5'd9, 5'd31)));
      send_item(exec_item(enc_r(FN_SRL, 5'd0, 5'd1, 5'd9, 5'd31)));
      // r0 stays zero
      send_item(exec_item(enc_i(OP_ADDIU, 5'd1, REG_ZERO, 16'h0005)));
   endtask

   task automatic test_memory_access();
      send_item(exec_item(enc_i(OP_LW, REG_SP, 5'd10, 16'hFFFC)));
      send_item(exec_item(enc_i(OP_SW, REG_SP, 5'd1, 16'hE000)));
      send_item(exec_item(enc_i(OP_LW, REG_SP, 5'd12, 16'hE000)));
   endtask

   task automatic test_control_flow();
      send_item(exec_item(enc_i(OP_BEQ, 5'd1, 5'd1, 16'h0003)));
      send_item(exec_item(enc_i(OP_BEQ, REG_ZERO, 5'd1, 16'hFFFF)));
      send_item(exec_item(enc_i(OP_BNE, 5'd1, REG_ZERO, 16'h8000)));
      send_item(exec_item(enc_i(OP_BNE, 5'd1, 5'd1, 16'h7FFF)));
      send_item(exec_item(enc_j(OP_J, 26'h3FF_FFFF)));
      send_item(exec_item(enc_j(OP_JAL, 26'h000_0000)));
      send_item(exec_item(enc_r(FN_JR, REG_RA, 5'd0, 5'd0, 5'd0)));
   endtask

   task automatic test_random_program();
      req_type item;
      for (int i = 0; i < 800; i++) begin
         idle_pct = (i >= 300 && i < 450) ? 0 : 26;
         build_random_item(item);
         send_item(item);
      end
      idle_pct = 26;
   endtask

   // only the first fault is visible, so the case is picked at random per run
   task automatic test_fault_halt();
      req_type    item;
      logic [5:0] bad, mem_op;
      send_item(exec_item(enc_i(OP_LUI, 5'($urandom), 5'd20, BASE_ADDR[31:16])));
      halt_case = halt_case_type'($urandom_range(4));
      mem_op    = $urandom_range(1) ? OP_LW : OP_SW;
      case (halt_case)
         HALT_BAD_OPCODE: begin
            do bad = 6'($urandom);
            while (bad inside {OP_RTYPE, OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDI, OP_ADDIU,
                               OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW});
            item = exec_item({bad, 26'($urandom)});
         end
         HALT_BAD_FUNCT: begin
            do bad = 6'($urandom);
            while (bad inside {FN_SLL, FN_SRL, FN_JR, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
                               FN_AND, FN_OR, FN_SLT});
            item = exec_item(enc_r(bad, 5'($urandom), 5'($urandom), 5'($urandom),
                                   5'($urandom)));
         end
         HALT_MISALIGNED:
            item = exec_item(enc_i(mem_op, 5'd20, 5'd21, 16'($urandom_range(3, 1))));
         HALT_BELOW_WINDOW:
            item = exec_item(enc_i(mem_op, 5'd20, 5'd21, 16'hFFFC));
         default:
            item = exec_item(enc_i(mem_op, 5'd20, 5'd21, 16'(4 * MEM_WORDS)));
      endcase
      send_item(item);
      // halted: execute items report only the pc, preloads still land
      repeat (30) begin
         case ($urandom_range(2))
            0: item = exec_item($urandom);
            1: build_random_item(item);
            default: item = load_item($urandom_range(MEM_WORDS - 1), $urandom);
         endcase
         send_item(item);
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(negedge clock) rsp_ready <= ($urandom_range(99) >= idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (retire_queue.size() == 0) begin
            $error("result with no item pending: %p", rsp_data);
            mismatch_count++;
         end else begin
            oldest = retire_queue.pop_front();
            compare_field("next_pc", oldest.next_pc, rsp_data.next_pc);
            compare_field("reg_written", 32'(oldest.reg_written), 32'(rsp_data.reg_written));
            compare_field("reg_index", 32'(oldest.reg_index), 32'(rsp_data.reg_index));
            compare_field("reg_value", oldest.reg_value, rsp_data.reg_value);
            compare_field("mem_written", 32'(oldest.mem_written), 32'(rsp_data.mem_written));
            compare_field("mem_address", oldest.mem_address, rsp_data.mem_address);
            compare_field("mem_value", oldest.mem_value, rsp_data.mem_value);
            compare_field("fault", 32'(oldest.fault), 32'(rsp_data.fault));
            results_checked++;
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      for (int i = 0; i < 32; i++) gpr[i] = '0;
      gpr[REG_SP] = BASE_ADDR + 32'(4 * MEM_WORDS);
      pc_q        = BASE_ADDR;
      halted_q    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_preload();
      test_alu_ops();
      test_memory_access();
      test_control_flow();
      test_random_program();
      test_fault_halt();

      @(negedge clock);
      req_valid <= 1'b0;
      while (retire_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Ran %0d items (%0d memory preloads), %0d results checked, %0d mismatches",
               items_sent, preloads_sent, results_checked, mismatch_count);
      $display("Sticky halt entered through %s", halt_case.name());
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: mips_subset_instruction_executor.f
sv/mse_pkg.sv
sv/mips_subset_instruction_executor.sv
test/testbench.sv
